### sv/ils_pkg.sv
// Package with the shared types and codes of the indexed LIFO stack.
`default_nettype none

package ils_pkg;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_CHANGE  = 3'd2,
    OP_PEEK    = 3'd3,
    OP_DISPLAY = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEK,
    S_DISP
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] data_in;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [3:0]  depth_count;
    logic [3:0]  entry_number;
    logic        final_item;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    change;
    logic    clear;
    logic    rd_peek;
    logic    rd_first;
    logic    rd_next;
    logic    emit;
    logic    emit_data;
    logic    emit_num;
    logic    emit_last;
    status_e emit_status;
  } cmd_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_bad;
    logic disp_last;
  } stat_t;

endpackage

`default_nettype wire

### sv/indexed_lifo_stack.sv
// Top level of the indexed LIFO stack.
//
// A request word (req_i: func, data_in, position) is taken at a rising edge
// where start is high and busy is low. Results come out on result_o, each one
// marked by result_valid_o for exactly one cycle; the receiver cannot stall.
// Push, pop, change, clear, unknown codes and every refused request give one
// result in the cycle after the request is taken, and busy stays low, so a
// new request can be taken every cycle.
// Peek gives its result through the result register and holds busy high for
// one cycle, because the stored word comes through the RAM's registered read
// port. Display of n stored words gives n results, one per cycle, through the
// RAM's registered read port and the result register, numbered from 1 at the
// top with final_item on the last; busy is high until the last word is handed
// to the result register, one RAM read per word.
// Each result reports a status code and the entry count after the request.
// Reset empties the stack; no result is given until a request is taken.
// Stored words have no reset and are read only after they were written.
`default_nettype none

module indexed_lifo_stack
  import ils_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      result_valid_o,
  output rsp_t      result_o
);

  cmd_t  cmd;
  stat_t stat;

  ils_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (req_i.func),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  ils_dp #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

### sv/ils_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/ils_ctrl.sv
// Controller state machine of the indexed LIFO stack.
`default_nettype none

module ils_ctrl
  import ils_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [2:0] func_i,
  input  wire stat_t      stat_i,
  output logic            busy,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !stat_i.empty && !stat_i.pos_bad && (op_e'(func_i) == OP_PEEK)) begin
          state_d = S_PEEK;
        end else if (accept && !stat_i.empty && (op_e'(func_i) == OP_DISPLAY)) begin
          state_d = S_DISP;
        end
      end
      S_PEEK: state_d = S_IDLE;
      S_DISP: begin
        if (stat_i.disp_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          case (op_e'(func_i))
            OP_PUSH: begin
              if (stat_i.full) begin
                cmd_o.emit_status = ST_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            OP_POP: begin
              if (stat_i.empty) begin
                cmd_o.emit_status = ST_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            OP_CHANGE: begin
              if (stat_i.empty) begin
                cmd_o.emit_status = ST_EMPTY;
              end else if (stat_i.pos_bad) begin
                cmd_o.emit_status = ST_RANGE;
              end else begin
                cmd_o.change = 1'b1;
              end
            end
            OP_PEEK: begin
              if (stat_i.empty) begin
                cmd_o.emit_status = ST_EMPTY;
              end else if (stat_i.pos_bad) begin
                cmd_o.emit_status = ST_RANGE;
              end else begin
                // The word comes back from the RAM in the next cycle.
                cmd_o.emit    = 1'b0;
                cmd_o.rd_peek = 1'b1;
              end
            end
            OP_DISPLAY: begin
              if (stat_i.empty) begin
                cmd_o.emit_status = ST_EMPTY;
              end else begin
                cmd_o.emit     = 1'b0;
                cmd_o.rd_first = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (stat_i.empty) begin
                cmd_o.emit_status = ST_EMPTY;
              end else begin
                cmd_o.clear = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_PEEK: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_data = 1'b1;
        cmd_o.emit_last = 1'b1;
      end
      S_DISP: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_data = 1'b1;
        cmd_o.emit_num  = 1'b1;
        cmd_o.emit_last = stat_i.disp_last;
        cmd_o.rd_next   = !stat_i.disp_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.push, cmd_o.pop, cmd_o.change, cmd_o.clear,
              cmd_o.rd_peek, cmd_o.rd_first, cmd_o.rd_next}))
    else $error("more than one stack action in a cycle");

  a_peek_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PEEK) |=> (state_q == S_IDLE))
    else $error("peek did not return to idle");

  a_read_then_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_peek || cmd_o.rd_first || cmd_o.rd_next) |=> (cmd_o.emit && cmd_o.emit_data))
    else $error("RAM read not followed by a word");

endmodule

`default_nettype wire

### sv/ils_dp.sv
// Datapath of the indexed LIFO stack: entry count, storage and result register.
`default_nettype none

module ils_dp
  import ils_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire req_t  req_i,
  input  wire cmd_t  cmd_i,
  output stat_t      stat_o,
  output logic       result_valid_o,
  output rsp_t       result_o
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         ent_q, ent_d;
  logic                  valid_q;
  rsp_t                  out_q;
  logic [CMPW-1:0]       cnt_w, pos_w, ent_w;
  logic [AW-1:0]         pos_addr, waddr, raddr;
  logic                  we, re;
  logic [WORD_WIDTH-1:0] rdata;

  assign cnt_w = CMPW'(count_q);
  assign pos_w = CMPW'(req_i.position);
  assign ent_w = CMPW'(ent_q);

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CW'(DEPTH));
  assign stat_o.pos_bad   = (pos_w == '0) || (pos_w > cnt_w);
  assign stat_o.disp_last = (ent_q == count_q);

  // Position 1 is the top entry, which sits at address count - 1.
  assign pos_addr = AW'(cnt_w - pos_w);

  assign we    = cmd_i.push || cmd_i.change;
  assign waddr = cmd_i.push ? AW'(count_q) : pos_addr;
  assign re    = cmd_i.rd_peek || cmd_i.rd_first || cmd_i.rd_next;

  always_comb begin
    if (cmd_i.rd_peek) begin
      raddr = pos_addr;
    end else if (cmd_i.rd_first) begin
      raddr = AW'(cnt_w - CMPW'(1));
    end else begin
      raddr = AW'(cnt_w - ent_w - CMPW'(1));
    end
  end

  ils_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (WORD_WIDTH'(req_i.data_in)),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.clear) begin
      count_d = '0;
    end
  end

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.rd_first) begin
      ent_d = CW'(1);
    end else if (cmd_i.rd_next) begin
      ent_d = ent_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ent_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ent_q   <= ent_d;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.data_out     <= cmd_i.emit_data ? 32'(rdata) : '0;
      out_q.status       <= cmd_i.emit_status;
      out_q.depth_count  <= 4'(count_d);
      out_q.entry_number <= cmd_i.emit_num ? 4'(ent_q) : '0;
      out_q.final_item   <= cmd_i.emit_last;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !stat_o.full)
    else $error("push issued on a full stack");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> (count_q == $past(count_q) - CW'(1)))
    else $error("pop did not lower the count by one");

endmodule

`default_nettype wire

### tb/sv/ils_checker.sv
// Checker for the indexed LIFO stack: tracks the stack, predicts result words, compares them.
module ils_checker
  import ils_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic result_valid_i,
  input  rsp_t result_i,
  output int   error_count_o,
  output int   pending_count_o
);

  logic [31:0] shadow_words [DEPTH];
  int          shadow_count;
  rsp_t        due_words [$];

  // Every result word reports the entry count after the request.
  function automatic void queue_word(input logic [31:0] data, input status_e status,
                                     input int num, input logic last);
    rsp_t w;
    w.data_out     = data;
    w.status       = status;
    w.depth_count  = 4'(shadow_count);
    w.entry_number = 4'(num);
    w.final_item   = last;
    due_words.push_back(w);
  endfunction

  function automatic void apply_request(input req_t r);
    int idx;
    case (r.func)
      OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          queue_word('0, ST_FULL, 0, 1'b1);
        end else begin
          shadow_words[shadow_count] = r.data_in;
          shadow_count++;
          queue_word('0, ST_OK, 0, 1'b1);
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          queue_word('0, ST_EMPTY, 0, 1'b1);
        end else begin
          shadow_count--;
          shadow_words[shadow_count] = '0;
          queue_word('0, ST_OK, 0, 1'b1);
        end
      end
      OP_CHANGE, OP_PEEK: begin
        if (shadow_count == 0) begin
          queue_word('0, ST_EMPTY, 0, 1'b1);
        end else if (r.position == 0 || int'(r.position) > shadow_count) begin
          queue_word('0, ST_RANGE, 0, 1'b1);
        end else begin
          idx = shadow_count - int'(r.position);
          if (r.func == OP_CHANGE) begin
            shadow_words[idx] = r.data_in;
            queue_word('0, ST_OK, 0, 1'b1);
          end else begin
            queue_word(shadow_words[idx], ST_OK, 0, 1'b1);
          end
        end
      end
      OP_DISPLAY: begin
        if (shadow_count == 0) begin
          queue_word('0, ST_EMPTY, 0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            queue_word(shadow_words[shadow_count - 1 - i], ST_OK, i + 1,
                       (i + 1 == shadow_count));
          end
        end
      end
      OP_CLEAR: begin
        if (shadow_count == 0) begin
          queue_word('0, ST_EMPTY, 0, 1'b1);
        end else begin
          for (int i = 0; i < DEPTH; i++) shadow_words[i] = '0;
          shadow_count = 0;
          queue_word('0, ST_OK, 0, 1'b1);
        end
      end
      default: begin
        // Unused codes leave the stack alone but still answer.
        queue_word('0, ST_OK, 0, 1'b1);
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) shadow_words[i] = '0;
      shadow_count = 0;
      due_words.delete();
      error_count_o   = 0;
      pending_count_o = 0;
    end else begin
      // A result word always belongs to a request taken at an earlier edge,
      // so it is compared before this edge's request is predicted.
      if (result_valid_i) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0h",
                   $time, result_i);
          error_count_o++;
        end else begin
          check_field("data_out", due_words[0].data_out, result_i.data_out);
          check_field("status", 32'(due_words[0].status), 32'(result_i.status));
          check_field("depth_count", 32'(due_words[0].depth_count),
                      32'(result_i.depth_count));
          check_field("entry_number", 32'(due_words[0].entry_number),
                      32'(result_i.entry_number));
          check_field("final_item", 32'(due_words[0].final_item),
                      32'(result_i.final_item));
          void'(due_words.pop_front());
        end
      end
      if (start_i && !busy_i) apply_request(req_i);
      pending_count_o = due_words.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Testbench top for the indexed LIFO stack: clock, reset, request words and the verdict.
module testbench;
  import ils_pkg::*;

  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;
  localparam int         PHASE_ITEMS  = 70;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic result_valid;
  rsp_t result;
  int   error_count;
  int   pending_count;

  indexed_lifo_stack i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  ils_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .req_i           (req),
    .result_valid_i  (result_valid),
    .result_i        (result),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Holds a request word from the falling edge until a rising edge takes it.
  task automatic issue(input logic [2:0] func, input logic [31:0] data,
                       input logic [3:0] pos);
    @(negedge clk_i);
    start <= 1'b1;
    req   <= '{func: func, data_in: data, position: pos};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_gaps(input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Filling mode favors push so the stack reaches full; draining favors pop.
  function automatic logic [2:0] pick_func(input bit filling);
    int r;
    r = $urandom_range(99);
    if (r < (filling ? 40 : 12)) return OP_PUSH;
    if (r < 52) return OP_POP;
    if (r < 66) return OP_CHANGE;
    if (r < 82) return OP_PEEK;
    if (r < 92) return OP_DISPLAY;
    if (r < 96) return OP_CLEAR;
    return $urandom_range(1) ? FUNC_SPARE_A : FUNC_SPARE_B;
  endfunction

  initial begin
    int          sender_pct;
    logic [31:0] data;
    logic [3:0]  pos;
    int          r;

    rst_ni = 1'b0;
    start  = 1'b0;
    req    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Everything refused on an empty stack, then the unused codes.
    issue(OP_POP, '0, 4'd1);
    issue(OP_PEEK, '0, 4'd1);
    issue(OP_CHANGE, 32'hFFFF_FFFF, 4'd1);
    issue(OP_DISPLAY, '0, '0);
    issue(OP_CLEAR, '0, '0);
    issue(FUNC_SPARE_A, 32'hFFFF_FFFF, 4'hF);
    issue(FUNC_SPARE_B, '0, '0);
    // Fill to capacity, starting with extreme words, then overflow.
    issue(OP_PUSH, 32'h0000_0000, '0);
    issue(OP_PUSH, 32'hFFFF_FFFF, 4'hF);
    for (int i = 0; i < 6; i++) issue(OP_PUSH, $urandom, 4'(i));
    issue(OP_PUSH, 32'h1234_5678, '0);
    // Positions outside 1..count, then the top and bottom entries.
    issue(OP_PEEK, '0, 4'd0);
    issue(OP_PEEK, '0, 4'd9);
    issue(OP_CHANGE, 32'hDEAD_BEEF, 4'hF);
    issue(OP_PEEK, '0, 4'd1);
    issue(OP_PEEK, '0, 4'd8);
    issue(OP_CHANGE, 32'hA5A5_A5A5, 4'd1);
    issue(OP_CHANGE, 32'h5A5A_5A5A, 4'd8);
    issue(OP_DISPLAY, '0, '0);
    issue(OP_POP, '0, '0);
    issue(OP_CLEAR, '0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       sender_pct = 66;
        3:       sender_pct = 24;
        default: sender_pct = 0;
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(9);
        if (r == 0) data = '0;
        else if (r == 1) data = 32'hFFFF_FFFF;
        else data = $urandom;
        if ($urandom_range(99) < 85) pos = 4'($urandom_range(8, 1));
        else pos = 4'($urandom_range(15));
        idle_gaps(sender_pct);
        issue(pick_func(((k / 12) % 2) == 0), data, pos);
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
